>>> rtl/abdh_pkg.sv
// Shared types and constants for the adjacent byte difference histogram.
// No dependencies.
`default_nettype none
package abdh_pkg;

  localparam int BIN_COUNT_DEF     = 256;
  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int BYTE_W            = 8;
  localparam int CFG_W             = 9;
  localparam int OUT_W             = 32;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_INC    = 2'd0,
    OP_READ   = 2'd1,
    OP_RDZERO = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [BYTE_W-1:0] byte_value;
    logic [BYTE_W-1:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic             bin_in_range;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] addr;
  } q_entry_t;

endpackage
`default_nettype wire

>>> rtl/adjacent_byte_difference_histogram.sv
// Adjacent byte difference histogram, top level.
// A read result passes the request queue, stage-one and result registers.
// Throughput: one request per cycle, set by the counter RAM read-modify-write
// port with write forwarding; a waiting result stalls the back end once a read
// reaches stage one, and the front once the queue fills.
// Reset: control and per-bin valid bits clear at once, no sweep; bins_r = 256.
// Depends on abdh_pkg, abdh_front, abdh_fifo, abdh_back.
`default_nettype none
module adjacent_byte_difference_histogram #(
  parameter int BIN_COUNT     = abdh_pkg::BIN_COUNT_DEF,
  parameter int COUNTER_WIDTH = abdh_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [abdh_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                       in_push,
  input  wire abdh_pkg::in_item_t         in_item,
  output logic                            in_full,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output abdh_pkg::out_item_t             out_item
);
  import abdh_pkg::*;

  q_entry_t fq_wr_data, fq_rd_data;
  logic     fq_push, fq_full, fq_pop, fq_empty;

  abdh_front #(
    .BIN_COUNT (BIN_COUNT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_item     (in_item),
    .in_full     (in_full),
    .q_push      (fq_push),
    .q_data      (fq_wr_data),
    .q_full      (fq_full)
  );

  abdh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data (fq_wr_data),
    .full    (fq_full),
    .pop     (fq_pop),
    .rd_data (fq_rd_data),
    .empty   (fq_empty)
  );

  abdh_back #(
    .BIN_COUNT     (BIN_COUNT),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (fq_rd_data),
    .q_empty   (fq_empty),
    .q_pop     (fq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> rtl/abdh_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
`default_nettype none
module abdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/abdh_fifo.sv
// Short request queue between front and back.
// Depends on abdh_pkg.
`default_nettype none
module abdh_fifo #(
  parameter int DEPTH = abdh_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire abdh_pkg::q_entry_t wr_data,
  output logic                    full,
  input  wire logic               pop,
  output abdh_pkg::q_entry_t      rd_data,
  output logic                    empty
);
  import abdh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/abdh_front.sv
// Front end: accepts requests, holds the previous byte and the bin limit, and
// queues reads, clears and in-range byte differences. Depends on abdh_pkg.
`default_nettype none
module abdh_front #(
  parameter int BIN_COUNT = abdh_pkg::BIN_COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [abdh_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                      in_push,
  input  wire abdh_pkg::in_item_t        in_item,
  output logic                           in_full,
  output logic                           q_push,
  output abdh_pkg::q_entry_t             q_data,
  input  wire logic                      q_full
);
  import abdh_pkg::*;

  localparam logic [CFG_W-1:0] BIN_LIMIT = CFG_W'(BIN_COUNT);

  logic [CFG_W-1:0]  bins_r;
  logic [CFG_W-1:0]  active;
  logic [BYTE_W-1:0] prev_r;
  logic              prev_vld_r;
  logic [BYTE_W-1:0] diff;
  logic              accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign active  = (bins_r > BIN_LIMIT) ? BIN_LIMIT : bins_r;
  assign diff    = (in_item.byte_value >= prev_r) ? in_item.byte_value - prev_r
                                                  : prev_r - in_item.byte_value;

  always_comb begin
    q_push      = 1'b0;
    q_data.op   = OP_INC;
    q_data.addr = diff;
    unique case (in_item.func)
      FUNC_DATA: begin
        q_push = accept && prev_vld_r && ({1'b0, diff} < active);
      end
      FUNC_READ: begin
        q_push      = accept;
        q_data.addr = in_item.bin_index;
        q_data.op   = ({1'b0, in_item.bin_index} < active) ? OP_READ : OP_RDZERO;
      end
      FUNC_CLEAR: begin
        q_push    = accept;
        q_data.op = OP_CLEAR;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r     <= CFG_RESET;
      prev_r     <= '0;
      prev_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bins_r <= cfg_wr_data;
      end
      if (accept && in_item.func == FUNC_DATA) begin
        prev_r     <= in_item.byte_value;
        prev_vld_r <= 1'b1;
      end else if (accept && in_item.func == FUNC_CLEAR) begin
        prev_r     <= '0;
        prev_vld_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/abdh_back.sv
// Back end: counter RAM read-modify-write with forwarding, per-bin valid bits,
// bin reads and the result register. Depends on abdh_pkg and abdh_ram.
`default_nettype none
module abdh_back #(
  parameter int BIN_COUNT     = abdh_pkg::BIN_COUNT_DEF,
  parameter int COUNTER_WIDTH = abdh_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire abdh_pkg::q_entry_t q_data,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output abdh_pkg::out_item_t     out_item
);
  import abdh_pkg::*;

  localparam int AW = $clog2(BIN_COUNT);

  logic                     s1_vld_r;
  op_t                      s1_op_r;
  logic [AW-1:0]            s1_addr_r;
  logic [BIN_COUNT-1:0]     vld_r;
  logic                     fwd_vld_r;
  logic [AW-1:0]            fwd_addr_r;
  logic [COUNTER_WIDTH-1:0] fwd_data_r;
  logic                     out_vld_r;
  out_item_t                out_item_r;

  logic [COUNTER_WIDTH-1:0] rdata, cur, inc_val;
  logic [OUT_W-1:0]         cnt_out;
  logic                     out_free, s1_is_rd, s1_done, wr_en;

  assign out_free = !out_vld_r || out_pop;
  assign s1_is_rd = (s1_op_r == OP_READ) || (s1_op_r == OP_RDZERO);
  assign s1_done  = s1_vld_r && (!s1_is_rd || out_free);
  assign q_pop    = !q_empty && (!s1_vld_r || s1_done);
  assign wr_en    = s1_done && (s1_op_r == OP_INC);

  always_comb begin
    if (fwd_vld_r && fwd_addr_r == s1_addr_r) begin
      cur = fwd_data_r;
    end else if (vld_r[s1_addr_r]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
  end

  assign inc_val = (&cur) ? cur : cur + 1'b1;

  if (COUNTER_WIDTH > OUT_W) begin : g_sat
    assign cnt_out = (|cur[COUNTER_WIDTH-1:OUT_W]) ? '1 : cur[OUT_W-1:0];
  end else if (COUNTER_WIDTH == OUT_W) begin : g_same
    assign cnt_out = cur;
  end else begin : g_ext
    assign cnt_out = {{(OUT_W-COUNTER_WIDTH){1'b0}}, cur};
  end

  abdh_ram #(
    .WIDTH (COUNTER_WIDTH),
    .DEPTH (BIN_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (inc_val),
    .re    (q_pop),
    .raddr (q_data.addr[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      vld_r     <= '0;
      fwd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_vld_r <= 1'b1;
      end else if (s1_done) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_done) begin
        fwd_vld_r <= wr_en;
        if (s1_op_r == OP_CLEAR) begin
          vld_r <= '0;
        end else if (wr_en) begin
          vld_r[s1_addr_r] <= 1'b1;
        end
      end
      if (s1_done && s1_is_rd) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op_r   <= q_data.op;
      s1_addr_r <= q_data.addr[AW-1:0];
    end
    if (wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= inc_val;
    end
    if (s1_done && s1_is_rd) begin
      out_item_r.bin_in_range <= (s1_op_r == OP_READ);
      out_item_r.bin_count    <= (s1_op_r == OP_READ) ? cnt_out : '0;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
